### rtl/lsgm_pkg.sv
// shared types, constants and microcode rom for the laser scan grid marker
package lsgm_pkg;

	localparam int GRID_ROWS_DEF = 64;
	localparam int GRID_COLS_DEF = 64;
	localparam int MAX_BEAMS     = 2048;

	localparam int UPC_W   = 5;
	localparam int COORD_W = 12;
	localparam int ANG_W   = 29;
	localparam int PROD_W  = 60;
	localparam int PH_W    = 48;
	localparam int XY_W    = 34;
	localparam int Z_W     = 33;
	localparam int PX_W    = 51;
	localparam int SUM_W   = 52;
	localparam int FRAC_SH = 40;
	localparam int ITERS   = 16;
	localparam int IT_W    = 4;

	localparam logic signed [30:0]     PHASE_MUL = 31'sd683565276;
	localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sh026DD3B6A;

	localparam logic [6:0]  ROBOT_X_RST     = 7'd1;
	localparam logic [6:0]  ROBOT_Y_RST     = 7'd0;
	localparam logic [15:0] ANGLE_STEP_RST  = 16'd286;
	localparam logic [11:0] BEAM_COUNT_RST  = 12'd1080;
	localparam logic [15:0] RANGE_LIMIT_RST = 16'd30720;

	typedef enum logic [1:0] {
		OP_BEAM  = 2'd0,
		OP_ROBOT = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		R_ROBOT_X     = 3'd0,
		R_ROBOT_Y     = 3'd1,
		R_ANGLE_STEP  = 3'd2,
		R_BEAM_COUNT  = 3'd3,
		R_RANGE_LIMIT = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		A_NONE,
		A_CLEAR,
		A_TAKE,
		A_MUL_ANGLE,
		A_MUL_PHASE,
		A_CORDIC_INIT,
		A_ROTATE,
		A_MUL_END,
		A_ADD_END,
		A_TRUNC_END,
		A_ROBOT,
		A_MARK,
		A_READ_COORD,
		A_READ_DATA,
		A_NULL,
		A_OUTPUT
	} micro_act_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_CLR_BUSY,
		C_NO_INPUT,
		C_IS_READ,
		C_IS_ROBOT,
		C_NO_BEAM,
		C_ITER_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		micro_act_t        act;
		cond_t             hold;
		cond_t             jump;
		logic [UPC_W-1:0]  target;
	} ctrl_word_t;

	localparam logic [UPC_W-1:0] S_CLEAR      = 5'd0;
	localparam logic [UPC_W-1:0] S_WAIT       = 5'd1;
	localparam logic [UPC_W-1:0] S_DEC_READ   = 5'd2;
	localparam logic [UPC_W-1:0] S_DEC_ROBOT  = 5'd3;
	localparam logic [UPC_W-1:0] S_DEC_BEAM   = 5'd4;
	localparam logic [UPC_W-1:0] S_MUL_ANGLE  = 5'd5;
	localparam logic [UPC_W-1:0] S_MUL_PHASE  = 5'd6;
	localparam logic [UPC_W-1:0] S_INIT       = 5'd7;
	localparam logic [UPC_W-1:0] S_ROTATE     = 5'd8;
	localparam logic [UPC_W-1:0] S_MUL_END    = 5'd9;
	localparam logic [UPC_W-1:0] S_ADD_END    = 5'd10;
	localparam logic [UPC_W-1:0] S_TRUNC_END  = 5'd11;
	localparam logic [UPC_W-1:0] S_ROBOT      = 5'd12;
	localparam logic [UPC_W-1:0] S_MARK       = 5'd13;
	localparam logic [UPC_W-1:0] S_READ_COORD = 5'd14;
	localparam logic [UPC_W-1:0] S_READ_WAIT  = 5'd15;
	localparam logic [UPC_W-1:0] S_READ_DATA  = 5'd16;
	localparam logic [UPC_W-1:0] S_NULL       = 5'd17;
	localparam logic [UPC_W-1:0] S_DONE       = 5'd18;

	function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] a);
		ctrl_word_t w;
		w = '{act: A_NONE, hold: C_NEVER, jump: C_NEVER, target: S_WAIT};
		unique case (a)
			S_CLEAR:      w = '{act: A_CLEAR, hold: C_CLR_BUSY, jump: C_NEVER, target: S_WAIT};
			S_WAIT:       w = '{act: A_TAKE, hold: C_NO_INPUT, jump: C_NEVER, target: S_WAIT};
			S_DEC_READ:   w = '{act: A_NONE, hold: C_NEVER, jump: C_IS_READ, target: S_READ_COORD};
			S_DEC_ROBOT:  w = '{act: A_NONE, hold: C_NEVER, jump: C_IS_ROBOT, target: S_ROBOT};
			S_DEC_BEAM:   w = '{act: A_NONE, hold: C_NEVER, jump: C_NO_BEAM, target: S_NULL};
			S_MUL_ANGLE:  w = '{act: A_MUL_ANGLE, hold: C_NEVER, jump: C_NEVER, target: S_WAIT};
			S_MUL_PHASE:  w = '{act: A_MUL_PHASE, hold: C_NEVER, jump: C_NEVER, target: S_WAIT};
			S_INIT:       w = '{act: A_CORDIC_INIT, hold: C_NEVER, jump: C_NEVER, target: S_WAIT};
			S_ROTATE:     w = '{act: A_ROTATE, hold: C_ITER_MORE, jump: C_NEVER, target: S_WAIT};
			S_MUL_END:    w = '{act: A_MUL_END, hold: C_NEVER, jump: C_NEVER, target: S_WAIT};
			S_ADD_END:    w = '{act: A_ADD_END, hold: C_NEVER, jump: C_NEVER, target: S_WAIT};
			S_TRUNC_END:  w = '{act: A_TRUNC_END, hold: C_NEVER, jump: C_ALWAYS, target: S_MARK};
			S_ROBOT:      w = '{act: A_ROBOT, hold: C_NEVER, jump: C_NEVER, target: S_WAIT};
			S_MARK:       w = '{act: A_MARK, hold: C_NEVER, jump: C_ALWAYS, target: S_DONE};
			S_READ_COORD: w = '{act: A_READ_COORD, hold: C_NEVER, jump: C_NEVER, target: S_WAIT};
			S_READ_WAIT:  w = '{act: A_NONE, hold: C_NEVER, jump: C_NEVER, target: S_WAIT};
			S_READ_DATA:  w = '{act: A_READ_DATA, hold: C_NEVER, jump: C_ALWAYS, target: S_DONE};
			S_NULL:       w = '{act: A_NULL, hold: C_NEVER, jump: C_NEVER, target: S_WAIT};
			S_DONE:       w = '{act: A_OUTPUT, hold: C_OUT_BUSY, jump: C_ALWAYS, target: S_WAIT};
			default:      w = '{act: A_NONE, hold: C_NEVER, jump: C_ALWAYS, target: S_WAIT};
		endcase
		return w;
	endfunction

	// arctangent of 2^-i in 2^32 turns
	function automatic logic [31:0] atan_turns(input logic [IT_W-1:0] i);
		logic [31:0] v;
		v = '0;
		unique case (i)
			4'd0:    v = 32'h20000000;
			4'd1:    v = 32'h12E4051E;
			4'd2:    v = 32'h09FB385B;
			4'd3:    v = 32'h051111D4;
			4'd4:    v = 32'h028B0D43;
			4'd5:    v = 32'h0145D7E1;
			4'd6:    v = 32'h00A2F61E;
			4'd7:    v = 32'h00517C55;
			4'd8:    v = 32'h0028BE53;
			4'd9:    v = 32'h00145F2F;
			4'd10:   v = 32'h000A2F98;
			4'd11:   v = 32'h000517CC;
			4'd12:   v = 32'h00028BE6;
			4'd13:   v = 32'h000145F3;
			4'd14:   v = 32'h0000A2FA;
			4'd15:   v = 32'h0000517D;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### rtl/laser_scan_grid_marker.sv
// laser scan occupancy grid marker: microcoded sequencer, cordic datapath and grid memory
// Keeps a GRID_ROWS x GRID_COLS grid of 2-bit cells in one memory with a write port and a
// registered read port. After reset a clearing pass writes every cell to zero, one per
// cycle; item_stall stays high during it while configuration writes are taken. A beam
// sample runs through the sequencer in steps: six to decode, scale the angle and load the
// cordic, 16 rotations of the shared shift-add cordic unit, five to scale the endpoint,
// mark the cell and hand the result over, and the step that takes the next transfer.
// Marking the robot cell, reading a cell and an ignored item take a shorter path of six
// steps each. One item is worked on at a time; the next is taken while the previous
// result waits in the output register, and a result that cannot enter the output register
// holds the sequencer in its last step. Configure only while the block is idle.
module laser_scan_grid_marker #(
	parameter int GRID_ROWS = lsgm_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLS = lsgm_pkg::GRID_COLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,

	input  logic              item_valid,
	output logic              item_stall,
	input  logic [1:0]        operation,
	input  logic [10:0]       beam_index,
	input  logic [15:0]       beam_range,
	input  logic [6:0]        cell_row,
	input  logic [6:0]        cell_col,

	output logic              result_valid,
	input  logic              result_stall,
	output logic signed [8:0] target_row,
	output logic signed [8:0] target_col,
	output logic [1:0]        cell_value,
	output logic              wrote,
	output logic              in_grid
);

	localparam int DEPTH = GRID_ROWS * GRID_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RAW   = $clog2(GRID_ROWS);
	localparam int CAW   = $clog2(GRID_COLS);
	localparam int CW    = lsgm_pkg::COORD_W;
	localparam int SW    = lsgm_pkg::SUM_W;
	localparam int FS    = lsgm_pkg::FRAC_SH;
	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
	localparam logic signed [CW-1:0] ROWS_C = CW'(GRID_ROWS);
	localparam logic signed [CW-1:0] COLS_C = CW'(GRID_COLS);
	localparam logic signed [CW-1:0] ONE_C  = CW'(1);
	localparam logic [lsgm_pkg::IT_W-1:0] IT_LAST = lsgm_pkg::IT_W'(lsgm_pkg::ITERS - 1);

	// configuration registers
	logic [6:0]         robot_x_q;
	logic signed [6:0]  robot_y_q;
	logic [15:0]        angle_step_q;
	logic [11:0]        beam_count_q;
	logic [15:0]        range_limit_q;

	// sequencer
	logic [lsgm_pkg::UPC_W-1:0] upc_q;
	logic [lsgm_pkg::UPC_W-1:0] upc_nxt;
	lsgm_pkg::ctrl_word_t       cw;
	logic                       hold_c;
	logic                       jump_c;

	// latched item
	lsgm_pkg::op_t op_q;
	logic [10:0]   idx_q;
	logic [15:0]   rng_q;
	logic [6:0]    crow_q;
	logic [6:0]    ccol_q;

	// datapath
	logic signed [11:0]                  k_val;
	logic signed [lsgm_pkg::ANG_W-1:0]   ang_prod;
	logic signed [lsgm_pkg::ANG_W-1:0]   ang_q;
	logic signed [lsgm_pkg::PROD_W-1:0]  ph_prod;
	logic [lsgm_pkg::PH_W-1:0]           ph_q;
	logic [31:0]                         phase;
	logic                                flip_q;
	logic signed [lsgm_pkg::XY_W-1:0]    x_q;
	logic signed [lsgm_pkg::XY_W-1:0]    y_q;
	logic signed [lsgm_pkg::Z_W-1:0]     z_q;
	logic signed [lsgm_pkg::XY_W-1:0]    dx;
	logic signed [lsgm_pkg::XY_W-1:0]    dy;
	logic signed [lsgm_pkg::Z_W-1:0]     at;
	logic [lsgm_pkg::IT_W-1:0]           iter_q;
	logic signed [lsgm_pkg::PX_W-1:0]    px_q;
	logic signed [lsgm_pkg::PX_W-1:0]    py_q;
	logic signed [SW-1:0]                rx_term;
	logic signed [SW-1:0]                ry_term;
	logic signed [SW-1:0]                sx_q;
	logic signed [SW-1:0]                sy_q;
	logic signed [CW-1:0]                ex;
	logic signed [CW-1:0]                ey;
	logic signed [CW-1:0]                row_q;
	logic signed [CW-1:0]                col_q;
	logic signed [CW-1:0]                row_m1;
	logic signed [CW-1:0]                col_m1;
	logic [1:0]                          mark_q;
	logic                                beam_ok;
	logic                                in_bounds;

	// result staging and output register
	logic [1:0] val_q;
	logic       wrote_q;
	logic       ingrid_q;
	logic       out_busy;
	logic       result_valid_q;
	logic [8:0] trow_q;
	logic [8:0] tcol_q;
	logic [1:0] cval_q;
	logic       owrote_q;
	logic       oingrid_q;

	// grid memory
	logic [1:0]    grid_mem [DEPTH];
	logic [AW-1:0] clr_cnt_q;
	logic [AW-1:0] cell_addr;
	logic [AW-1:0] mem_waddr;
	logic          mem_we;
	logic [1:0]    mem_wdata;
	logic [1:0]    rd_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			robot_x_q     <= lsgm_pkg::ROBOT_X_RST;
			robot_y_q     <= lsgm_pkg::ROBOT_Y_RST;
			angle_step_q  <= lsgm_pkg::ANGLE_STEP_RST;
			beam_count_q  <= lsgm_pkg::BEAM_COUNT_RST;
			range_limit_q <= lsgm_pkg::RANGE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (lsgm_pkg::cfg_reg_t'(cfg_index))
				lsgm_pkg::R_ROBOT_X:     robot_x_q     <= cfg_data[6:0];
				lsgm_pkg::R_ROBOT_Y:     robot_y_q     <= cfg_data[6:0];
				lsgm_pkg::R_ANGLE_STEP:  angle_step_q  <= cfg_data;
				lsgm_pkg::R_BEAM_COUNT:  beam_count_q  <= cfg_data[11:0];
				lsgm_pkg::R_RANGE_LIMIT: range_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer control
	assign cw       = lsgm_pkg::ucode_rom(upc_q);
	assign out_busy = result_valid_q && result_stall;

	assign beam_ok = (op_q == lsgm_pkg::OP_BEAM)
		&& ({1'b0, idx_q} < beam_count_q)
		&& (32'(idx_q) < lsgm_pkg::MAX_BEAMS)
		&& (rng_q < range_limit_q);

	function automatic logic eval_cond(input lsgm_pkg::cond_t c, input logic clr_busy,
		input logic no_in, input logic is_rd, input logic is_rb, input logic no_beam,
		input logic it_more, input logic o_busy);
		logic r;
		r = 1'b0;
		unique case (c)
			lsgm_pkg::C_NEVER:     r = 1'b0;
			lsgm_pkg::C_ALWAYS:    r = 1'b1;
			lsgm_pkg::C_CLR_BUSY:  r = clr_busy;
			lsgm_pkg::C_NO_INPUT:  r = no_in;
			lsgm_pkg::C_IS_READ:   r = is_rd;
			lsgm_pkg::C_IS_ROBOT:  r = is_rb;
			lsgm_pkg::C_NO_BEAM:   r = no_beam;
			lsgm_pkg::C_ITER_MORE: r = it_more;
			lsgm_pkg::C_OUT_BUSY:  r = o_busy;
			default:               r = 1'b0;
		endcase
		return r;
	endfunction

	always_comb begin
		hold_c = eval_cond(cw.hold, clr_cnt_q != CLR_LAST, !item_valid,
			op_q == lsgm_pkg::OP_READ, op_q == lsgm_pkg::OP_ROBOT, !beam_ok,
			iter_q != IT_LAST, out_busy);
		jump_c = eval_cond(cw.jump, clr_cnt_q != CLR_LAST, !item_valid,
			op_q == lsgm_pkg::OP_READ, op_q == lsgm_pkg::OP_ROBOT, !beam_ok,
			iter_q != IT_LAST, out_busy);
		if (hold_c) begin
			upc_nxt = upc_q;
		end else if (jump_c) begin
			upc_nxt = cw.target;
		end else begin
			upc_nxt = upc_q + lsgm_pkg::UPC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= lsgm_pkg::S_CLEAR;
		end else begin
			upc_q <= upc_nxt;
		end
	end

	assign item_stall = (cw.act != lsgm_pkg::A_TAKE);

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			op_q   <= lsgm_pkg::op_t'(operation);
			idx_q  <= beam_index;
			rng_q  <= beam_range;
			crow_q <= cell_row;
			ccol_q <= cell_col;
		end
	end

	// beam arithmetic
	assign k_val    = $signed({1'b0, idx_q}) - $signed({1'b0, beam_count_q[11:1]});
	assign ang_prod = lsgm_pkg::ANG_W'(k_val) * lsgm_pkg::ANG_W'($signed({1'b0, angle_step_q}));
	assign ph_prod  = lsgm_pkg::PROD_W'(ang_q) * lsgm_pkg::PROD_W'(lsgm_pkg::PHASE_MUL);
	assign phase    = ph_q[lsgm_pkg::PH_W-1:16];

	assign dx = x_q >>> iter_q;
	assign dy = y_q >>> iter_q;
	assign at = $signed({1'b0, lsgm_pkg::atan_turns(iter_q)});

	assign rx_term = $signed(SW'({robot_x_q, {FS{1'b0}}}));
	assign ry_term = $signed({{(SW - 7 - FS){robot_y_q[6]}}, robot_y_q, {FS{1'b0}}});

	assign ex = sx_q[SW-1:FS] + CW'({1'b0, sx_q[SW-1] && (|sx_q[FS-1:0])});
	assign ey = sy_q[SW-1:FS] + CW'({1'b0, sy_q[SW-1] && (|sy_q[FS-1:0])});

	always_ff @(posedge clk) begin
		unique case (cw.act)
			lsgm_pkg::A_MUL_ANGLE: begin
				ang_q <= ang_prod;
			end
			lsgm_pkg::A_MUL_PHASE: begin
				ph_q <= ph_prod[lsgm_pkg::PH_W-1:0];
			end
			lsgm_pkg::A_CORDIC_INIT: begin
				flip_q <= phase[31] ^ phase[30];
				x_q    <= lsgm_pkg::CORDIC_X0;
				y_q    <= '0;
				// folded phase keeps bit 30 as its sign
				z_q    <= $signed({phase[30], phase[30], phase[30:0]});
				iter_q <= '0;
			end
			lsgm_pkg::A_ROTATE: begin
				if (!z_q[lsgm_pkg::Z_W-1]) begin
					x_q <= x_q - dy;
					y_q <= y_q + dx;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dy;
					y_q <= y_q - dx;
					z_q <= z_q + at;
				end
				iter_q <= iter_q + lsgm_pkg::IT_W'(1);
			end
			lsgm_pkg::A_MUL_END: begin
				px_q <= lsgm_pkg::PX_W'($signed({1'b0, rng_q})) * lsgm_pkg::PX_W'(x_q);
				py_q <= lsgm_pkg::PX_W'($signed({1'b0, rng_q})) * lsgm_pkg::PX_W'(y_q);
			end
			lsgm_pkg::A_ADD_END: begin
				sx_q <= flip_q ? rx_term - SW'(px_q) : rx_term + SW'(px_q);
				sy_q <= flip_q ? ry_term - SW'(py_q) : ry_term + SW'(py_q);
			end
			lsgm_pkg::A_TRUNC_END: begin
				row_q  <= ROWS_C + ey;
				col_q  <= ex;
				mark_q <= 2'd1;
			end
			lsgm_pkg::A_ROBOT: begin
				row_q  <= ROWS_C + CW'(robot_y_q);
				col_q  <= CW'({1'b0, robot_x_q});
				mark_q <= 2'd2;
			end
			lsgm_pkg::A_MARK: begin
				val_q    <= in_bounds ? mark_q : 2'd0;
				wrote_q  <= in_bounds;
				ingrid_q <= in_bounds;
			end
			lsgm_pkg::A_READ_COORD: begin
				row_q <= CW'({1'b0, crow_q});
				col_q <= CW'({1'b0, ccol_q});
			end
			lsgm_pkg::A_READ_DATA: begin
				val_q    <= in_bounds ? rd_data_q : 2'd0;
				wrote_q  <= 1'b0;
				ingrid_q <= in_bounds;
			end
			lsgm_pkg::A_NULL: begin
				row_q    <= '0;
				col_q    <= '0;
				val_q    <= 2'd0;
				wrote_q  <= 1'b0;
				ingrid_q <= 1'b0;
			end
			default: ;
		endcase
	end

	// grid addressing and memory
	assign in_bounds = (row_q >= ONE_C) && (row_q <= ROWS_C) && (col_q >= ONE_C)
		&& (col_q <= COLS_C);
	assign row_m1 = row_q - ONE_C;
	assign col_m1 = col_q - ONE_C;
	assign cell_addr = AW'(row_m1[RAW-1:0]) * AW'(GRID_COLS) + AW'(col_m1[CAW-1:0]);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cell_addr;
		mem_wdata = mark_q;
		if (cw.act == lsgm_pkg::A_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = 2'd0;
		end else if (cw.act == lsgm_pkg::A_MARK) begin
			mem_we = in_bounds;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= grid_mem[cell_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cw.act == lsgm_pkg::A_CLEAR && clr_cnt_q != CLR_LAST) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cw.act == lsgm_pkg::A_OUTPUT && !out_busy) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.act == lsgm_pkg::A_OUTPUT && !out_busy) begin
			trow_q    <= row_q[8:0];
			tcol_q    <= col_q[8:0];
			cval_q    <= val_q;
			owrote_q  <= wrote_q;
			oingrid_q <= ingrid_q;
		end
	end

	assign result_valid = result_valid_q;
	assign target_row   = $signed(trow_q);
	assign target_col   = $signed(tcol_q);
	assign cell_value   = cval_q;
	assign wrote        = owrote_q;
	assign in_grid      = oingrid_q;

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(upc_q == lsgm_pkg::S_DONE))
		else $error("result raised outside the done step");

	a_wrote_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && wrote |-> in_grid)
		else $error("write reported for a cell outside the grid");

	a_value_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && cell_value != 2'd0 |-> in_grid)
		else $error("nonzero cell value outside the grid");

	a_rotate_start: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q == lsgm_pkg::S_ROTATE && $past(upc_q) == lsgm_pkg::S_INIT |-> iter_q == '0)
		else $error("cordic entered with nonzero iteration count");

endmodule
